/* rtl/core/byte_fifo_stream_defines.svh */
// Assertion macros for the byte FIFO stream block.
`ifndef BYTE_FIFO_STREAM_DEFINES_SVH
`define BYTE_FIFO_STREAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BFS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BFS_ASSERT(lbl, clk, rst_n, prop)
`define BFS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/core/bfs_pkg.sv */
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 32;
  localparam int RUN_W   = 7;
  localparam int MAX_RUN = 64;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
  } bfs_in_t;

  typedef struct packed {
    logic              accepted;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
    logic              closed;
    logic              at_eof;
    logic [TOT_W-1:0]  written_total;
    logic [TOT_W-1:0]  read_total;
  } bfs_out_t;

  typedef struct packed {
    logic commit;
    logic single;
    logic start;
    logic emit;
  } bfs_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic run_empty;
    logic run_one;
    logic rem_last;
  } bfs_stat_t;

endpackage

/* rtl/core/bfs_in_if.sv */
`timescale 1ns / 1ps

interface bfs_in_if import bfs_pkg::*; ();
  logic    valid;
  logic    ready;
  bfs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bfs_out_if.sv */
`timescale 1ns / 1ps

interface bfs_out_if import bfs_pkg::*; ();
  logic     valid;
  logic     ready;
  bfs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bfs_ctrl.sv */
`timescale 1ns / 1ps

module bfs_ctrl import bfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  input  logic              out_ready_i,
  input  bfs_stat_t         stat_i,
  output logic              in_ready_o,
  output bfs_cmd_t          cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic slot_free;
  logic run_kind;

  always_comb begin
    case (in_kind_i) inside
      KIND_READ, KIND_PEEK: run_kind = 1'b1;
      default:              run_kind = 1'b0;
    endcase
  end

  always_comb begin
    slot_free  = !stat_i.out_valid || out_ready_i;
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          cmd_o.commit = 1'b1;
          if (run_kind && !stat_i.run_empty) begin
            cmd_o.start = 1'b1;
            if (!stat_i.run_one) begin
              state_d = ST_RUN;
            end
          end else begin
            cmd_o.single = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.rem_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bfs_datapath.sv */
`timescale 1ns / 1ps
`include "byte_fifo_stream_defines.svh"

module bfs_datapath import bfs_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bfs_in_t   in_data_i,
  input  logic      out_ready_i,
  input  bfs_cmd_t  cmd_i,
  output bfs_stat_t stat_o,
  output logic      out_valid_o,
  output bfs_out_t  out_data_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > LEN_W) ? CW : LEN_W;
  localparam int SW = CW + 1;

  logic [BYTE_W-1:0] mem [CAPACITY];

  logic [IW-1:0]     wr_q, rd_q, cur_q;
  logic [CW-1:0]     fill_q;
  logic [TOT_W-1:0]  in_tot_q, out_tot_q;
  logic              ended_q;
  logic [RUN_W-1:0]  rem_q;
  logic              out_valid_q, acc_q, bval_q, last_q;
  logic [BYTE_W-1:0] rdata_q;

  logic [MW-1:0]     len_ext, fill_ext, n_pop_ext, n_run_ext, free_ext;
  logic [CW-1:0]     n_take;
  logic [SW-1:0]     rd_sum, rd_adv;
  logic              full, is_write, load_byte;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    len_ext   = MW'(in_data_i.length);
    fill_ext  = MW'(fill_q);
    n_pop_ext = (len_ext < fill_ext) ? len_ext : fill_ext;
    n_run_ext = (n_pop_ext > MW'(MAX_RUN)) ? MW'(MAX_RUN) : n_pop_ext;
    n_take    = (in_data_i.kind == KIND_POP) ? n_pop_ext[CW-1:0] : n_run_ext[CW-1:0];
    rd_sum    = SW'(rd_q) + SW'(n_take);
    rd_adv    = (rd_sum >= SW'(CAPACITY)) ? rd_sum - SW'(CAPACITY) : rd_sum;
    full      = (fill_q == CW'(CAPACITY));
    is_write  = (in_data_i.kind == KIND_WRITE);
    load_byte = cmd_i.start || cmd_i.emit;
    free_ext  = MW'(CAPACITY) - fill_ext;
  end

  assign stat_o.out_valid = out_valid_q;
  assign stat_o.run_empty = (n_run_ext == '0);
  assign stat_o.run_one   = (n_run_ext == MW'(1));
  assign stat_o.rem_last  = (rem_q == RUN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      fill_q    <= '0;
      in_tot_q  <= '0;
      out_tot_q <= '0;
      ended_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      case (in_data_i.kind) inside
        KIND_WRITE: begin
          if (!full) begin
            wr_q     <= idx_inc(wr_q);
            fill_q   <= fill_q + 1'b1;
            in_tot_q <= in_tot_q + 1'b1;
          end
        end
        KIND_READ, KIND_POP: begin
          rd_q      <= rd_adv[IW-1:0];
          fill_q    <= fill_q - n_take;
          out_tot_q <= out_tot_q + TOT_W'(n_take);
        end
        KIND_END: ended_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      bval_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cur_q <= idx_inc(rd_q);
        rem_q <= n_run_ext[RUN_W-1:0] - 1'b1;
      end else if (cmd_i.emit) begin
        cur_q <= idx_inc(cur_q);
        rem_q <= rem_q - 1'b1;
      end
      if (cmd_i.single) begin
        out_valid_q <= 1'b1;
        acc_q       <= is_write && !full;
        bval_q      <= 1'b0;
        last_q      <= 1'b1;
      end else if (load_byte) begin
        out_valid_q <= 1'b1;
        acc_q       <= 1'b0;
        bval_q      <= 1'b1;
        last_q      <= cmd_i.start ? stat_o.run_one : stat_o.rem_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_write && !full) begin
      mem[wr_q] <= in_data_i.data_byte;
    end
    if (load_byte) begin
      rdata_q <= mem[cmd_i.start ? rd_q : cur_q];
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.accepted      = acc_q;
  assign out_data_o.out_byte      = bval_q ? rdata_q : '0;
  assign out_data_o.byte_valid    = bval_q;
  assign out_data_o.last          = last_q;
  assign out_data_o.fill_level    = fill_ext[CNT_W-1:0];
  assign out_data_o.free_space    = free_ext[CNT_W-1:0];
  assign out_data_o.closed        = ended_q;
  assign out_data_o.at_eof        = ended_q && (fill_q == '0);
  assign out_data_o.written_total = in_tot_q;
  assign out_data_o.read_total    = out_tot_q;

  `BFS_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > CW'(CAPACITY))
  `BFS_ASSERT(a_load_slot, clk_i, rst_ni, (load_byte || cmd_i.single) |-> (!out_valid_q || out_ready_i))
  `BFS_ASSERT(a_tot_balance, clk_i, rst_ni, (in_tot_q - out_tot_q) == TOT_W'(fill_q))
  `BFS_ASSERT_NEVER(a_run_rem, clk_i, rst_ni, cmd_i.emit && (rem_q == '0))

endmodule

/* rtl/core/byte_fifo_stream.sv */
// Byte FIFO over a ring store of CAPACITY bytes.
// Input channel in_i (valid/ready): one operation per beat, kind selects
// write byte, read, peek, pop or end input. Output channel out_o
// (valid/ready): result beats, each with the status after its operation.
// Write, pop, end and unknown kinds give one result beat; read and peek
// give one beat per byte (min of length, fill level, 64) with last on the
// final beat, or one empty beat with last set when no byte is available.
// The first result beat is registered and shows in the cycle after the
// operation is taken. One single-result operation is taken per cycle if
// the receiver keeps up; a read or peek holds the input to its last beat,
// one byte per cycle via the registered store read port while unstalled.
// A new operation is taken while the previous result is being taken.
// When the receiver stalls, the result register holds and the input
// deasserts ready until the slot is free. Reset clears the pointers, fill
// level, totals and closed flag at once; no clearing pass is needed.
`timescale 1ns / 1ps

module byte_fifo_stream import bfs_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfs_in_if.sink    in_i,
  bfs_out_if.source out_o
);

  bfs_cmd_t  cmd;
  bfs_stat_t stat;

  bfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.data.kind),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  bfs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule
